/* rtl/core/rwnh_pkg.sv */
// Package for the nearest wall hit block: mode codes and shared types.
// No dependencies.
`timescale 1ns / 1ps
package rwnh_pkg;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_CAST   = 2'd3
  } mode_e;

  // Done word from the wall scan to the divider.
  typedef struct packed {
    logic start;
    logic any;
  } scan_done_t;

endpackage

/* rtl/core/rwnh_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rwnh_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/core/rwnh_div.sv */
// Restoring divider: floor(n * 2^QBits / d) for n < d, one bit per cycle.
// Depends on nothing; used by the top level.
`timescale 1ns / 1ps
module rwnh_div #(
  parameter int NBits = 34,
  parameter int QBits = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NBits-1:0] num_i,
  input  logic [NBits-1:0] den_i,
  output logic             done_o,
  output logic [QBits-1:0] quo_o
);
  localparam int CntW = $clog2(QBits + 1);

  logic [NBits:0]   rem_q, rem_d;
  logic [NBits-1:0] den_q;
  logic [QBits-1:0] quo_q, quo_d;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic [NBits:0]   sh;

  assign sh = {rem_q[NBits-1:0], 1'b0};

  always_comb begin
    rem_d = sh;
    quo_d = {quo_q[QBits-2:0], 1'b0};
    if (sh >= {1'b0, den_q}) begin
      rem_d    = sh - {1'b0, den_q};
      quo_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(QBits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i};
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quo_o = quo_q;
endmodule

/* rtl/core/rwnh_scan.sv */
// Wall scan: per-wall intersection test pipeline and nearest-hit keeper.
// Depends on rwnh_pkg; fed by RAM read data from the top level.
`timescale 1ns / 1ps
module rwnh_scan #(
  parameter int CoordBits = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clr_i,
  input  logic                     vld_i,
  input  logic                     last_i,
  input  logic [4*CoordBits-1:0]   wall_i,
  input  logic signed [CoordBits-1:0] fx_i,
  input  logic signed [CoordBits-1:0] fy_i,
  input  logic signed [CoordBits-1:0] sx_i,
  input  logic signed [CoordBits-1:0] sy_i,
  output rwnh_pkg::scan_done_t     done_o,
  output logic [2*CoordBits+1:0]   best_n_o,
  output logic [2*CoordBits+1:0]   best_d_o
);
  import rwnh_pkg::*;

  localparam int DW = CoordBits + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;
  localparam int NW = 2 * CoordBits + 2;

  logic signed [DW-1:0] rx, ry, wx, wy, dx, dy;
  logic signed [CoordBits-1:0] ax, ay, bx, by;

  assign {ax, ay, bx, by} = wall_i;
  assign rx = DW'(sx_i) - DW'(fx_i);
  assign ry = DW'(sy_i) - DW'(fy_i);
  assign wx = DW'(bx) - DW'(ax);
  assign wy = DW'(by) - DW'(ay);
  assign dx = DW'(fx_i) - DW'(ax);
  assign dy = DW'(fy_i) - DW'(ay);

  // stage 1: products
  logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic v1_q, l1_q, v2_q, l2_q, l3_q;

  // stage 2: normalized terms
  logic signed [SW-1:0] den, sn, tn;
  logic [SW-1:0] den_q, tn_q;
  logic ok_q;

  assign den = SW'(p0_q) - SW'(p1_q);
  assign sn  = SW'(p2_q) - SW'(p3_q);
  assign tn  = SW'(p4_q) - SW'(p5_q);

  logic signed [SW-1:0] dn, snn, tnn;
  always_comb begin
    dn  = den[SW-1] ? -den : den;
    snn = den[SW-1] ? -sn  : sn;
    tnn = den[SW-1] ? -tn  : tn;
  end

  // stage 3: compare tn/den against best via cross products
  logic [NW-1:0] bn_q, bd_q;
  logic [2*NW-1:0] lhs, rhs;
  logic any_q;
  assign lhs = (2*NW)'(tn_q[NW-1:0]) * (2*NW)'(bd_q);
  assign rhs = (2*NW)'(bn_q) * (2*NW)'(den_q[NW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0;
      l1_q <= 1'b0; l2_q <= 1'b0; l3_q <= 1'b0;
      ok_q <= 1'b0; any_q <= 1'b0;
      bn_q <= NW'(1); bd_q <= NW'(1);
      done_o <= '0;
    end else begin
      v1_q <= vld_i;  l1_q <= vld_i & last_i;
      v2_q <= v1_q;   l2_q <= l1_q;
      ok_q <= v1_q && (den != '0) && !snn[SW-1] && (snn <= dn)
              && !tnn[SW-1] && (tnn <= dn);
      l3_q <= l2_q;
      done_o.start <= l3_q;
      done_o.any   <= any_q;
      if (clr_i) begin
        any_q <= 1'b0;
        bn_q  <= NW'(1);
        bd_q  <= NW'(1);
      end else if (v2_q && ok_q) begin
        any_q <= 1'b1;
        if (lhs < rhs) begin
          bn_q <= tn_q[NW-1:0];
          bd_q <= den_q[NW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q <= rx * wy;
    p1_q <= wx * ry;
    p2_q <= rx * dy;
    p3_q <= ry * dx;
    p4_q <= wx * dy;
    p5_q <= wy * dx;
    den_q <= dn;
    tn_q  <= tnn;
  end

  assign best_n_o = bn_q;
  assign best_d_o = bd_q;
endmodule

/* rtl/core/ray_wall_nearest_hit.sv */
// Top level of the nearest wall hit block: command decode, wall table, scan, divide.
// Depends on rwnh_pkg, rwnh_ram, rwnh_scan, rwnh_div.
`timescale 1ns / 1ps
// Add, remove and clear words complete without leaving the idle state. A cast
// reads the wall table one entry per cycle from a single RAM port into a
// three-stage test pipeline, then runs a bit-serial divide of OUT_FRAC_BITS+2
// steps. One word is worked on at a time; a result held by out_stall_i stalls
// the input until it is taken.
module ray_wall_nearest_hit #(
  parameter int MAX_WALLS     = 64,
  parameter int COORD_BITS    = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic signed [15:0] first_x_i,
  input  logic signed [15:0] first_y_i,
  input  logic signed [15:0] second_x_i,
  input  logic signed [15:0] second_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [15:0] ray_value_o,
  output logic        hit_o
);
  import rwnh_pkg::*;

  localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
  localparam int CW = $clog2(MAX_WALLS + 1);
  localparam int NW = 2 * COORD_BITS + 2;
  localparam int QB = OUT_FRAC_BITS + 2;
  localparam int VW = QB + 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_WAIT = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic signed [COORD_BITS-1:0] fx_q, fy_q, sx_q, sy_q;
  logic acc, we, rd_vld_q, rd_last_q, issue, issue_last, clr, empty_cast;
  mode_e mode;
  scan_done_t sdone;
  logic [NW-1:0] bn, bd;
  logic div_start, div_done, any_q, full_q;
  logic [QB-1:0] quo;
  logic [4*COORD_BITS-1:0] rdata;

  assign mode = mode_e'(mode_i);
  assign acc  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_o && out_stall_i);
  assign we = acc && mode == MODE_ADD && cnt_q < CW'(MAX_WALLS);
  assign issue = state_q == ST_SCAN;
  assign issue_last = issue && (idx_q == cnt_q - 1'b1);
  assign clr = acc && mode == MODE_CAST;
  assign empty_cast = clr && cnt_q == '0;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          unique case (mode)
            MODE_ADD:    if (we) cnt_d = cnt_q + 1'b1;
            MODE_REMOVE: if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
            MODE_CLEAR:  cnt_d = '0;
            MODE_CAST: begin
              idx_d   = '0;
              state_d = (cnt_q == '0) ? ST_WAIT : ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        idx_d = idx_q + 1'b1;
        if (issue_last) state_d = ST_WAIT;
      end
      ST_WAIT: if (div_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0; idx_q <= '0;
      rd_vld_q <= 1'b0; rd_last_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d; idx_q <= idx_d;
      rd_vld_q <= issue; rd_last_q <= issue_last;
      if (div_done) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr) begin
      fx_q <= COORD_BITS'(first_x_i); fy_q <= COORD_BITS'(first_y_i);
      sx_q <= COORD_BITS'(second_x_i); sy_q <= COORD_BITS'(second_y_i);
    end
  end

  rwnh_ram #(.Width(4 * COORD_BITS), .Depth(MAX_WALLS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i({COORD_BITS'(first_x_i), COORD_BITS'(first_y_i),
              COORD_BITS'(second_x_i), COORD_BITS'(second_y_i)}),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(rdata)
  );

  rwnh_scan #(.CoordBits(COORD_BITS)) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (clr),
    .vld_i   (rd_vld_q),
    .last_i  (rd_last_q),
    .wall_i  (rdata),
    .fx_i    (fx_q), .fy_i(fy_q), .sx_i(sx_q), .sy_i(sy_q),
    .done_o  (sdone),
    .best_n_o(bn),
    .best_d_o(bd)
  );

  logic empty_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q <= 1'b0; any_q <= 1'b0; full_q <= 1'b0;
    end else begin
      empty_q <= empty_cast;
      if (div_start) begin
        any_q  <= sdone.start & sdone.any;
        full_q <= bn >= bd;
      end
    end
  end

  assign div_start = sdone.start || empty_q;

  rwnh_div #(.NBits(NW), .QBits(QB)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (bn >= bd ? '0 : bn),
    .den_i  (bd),
    .done_o (div_done),
    .quo_o  (quo)
  );

  logic [VW:0] qv, rq;
  logic signed [VW+1:0] val;
  assign qv  = full_q ? (VW+1)'(1) << QB : (VW+1)'(quo);
  assign rq  = (qv + 1'b1) >> 1;
  assign val = (VW+2)'(rq) - ((VW+2)'(1) << OUT_FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      if (val > (VW+2)'(32767)) ray_value_o <= 16'sd32767;
      else if (val < -(VW+2)'(32768)) ray_value_o <= -16'sd32768;
      else ray_value_o <= 16'(val);
      hit_o <= any_q;
    end
  end
endmodule
